FILE: hw/rtl/udr_pkg.sv
`default_nettype none

package udr_pkg;

	localparam int unsigned DividendWidth = 64;
	localparam int unsigned DivisorWidth  = 32;

	// One pipeline stage settles one quotient bit.
	localparam int unsigned NumStages = DividendWidth;

	// The working word of one item as it travels down the array.
	// acc starts as the dividend; each step shifts one dividend bit out at the top
	// and one quotient bit in at the bottom, so after the last step it holds the quotient.
	typedef struct packed {
		logic [DividendWidth-1:0] acc;
		logic [DivisorWidth-1:0]  rem;
		logic [DivisorWidth-1:0]  divisor;
	} udr_data_t;

	// One restoring division step. A zero divisor needs no special case here:
	// every step then subtracts nothing and sets its quotient bit, so the quotient
	// comes out as all ones and the remainder as the last 32 dividend bits shifted in.
	function automatic udr_data_t udr_step(input udr_data_t cur);
		logic [DivisorWidth:0] trial;
		logic [DivisorWidth:0] diff;
		logic                  fits;
		udr_data_t             nxt;
		trial = {cur.rem, cur.acc[DividendWidth-1]};
		diff  = trial - {1'b0, cur.divisor};
		fits  = (trial >= {1'b0, cur.divisor});
		nxt.acc     = {cur.acc[DividendWidth-2:0], fits};
		nxt.rem     = fits ? diff[DivisorWidth-1:0] : trial[DivisorWidth-1:0];
		nxt.divisor = cur.divisor;
		return nxt;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/udr_if.sv
`default_nettype none

// Request channel: one dividend and divisor pair per word.
interface udr_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [udr_pkg::DividendWidth-1:0]    dividend;
	logic [udr_pkg::DivisorWidth-1:0]     divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// Response channel: one quotient and remainder per word.
interface udr_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [udr_pkg::DividendWidth-1:0]    quotient;
	logic [udr_pkg::DivisorWidth-1:0]     remainder;
	logic                                 divide_by_zero;

	modport source (output valid, output quotient, output remainder, output divide_by_zero,
		input ready);
	modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/udr_stage.sv
`default_nettype none

// One row of the divider array: a single restoring step followed by its register.
module udr_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_in,
	input  wire udr_pkg::udr_data_t data_in,
	output logic                   valid_s1,
	output udr_pkg::udr_data_t     data_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= udr_pkg::udr_step(data_in);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/udiv64_by32_rem.sv
`default_nettype none

// Channel  Role   Payload                                         Handshake
// req      sink   dividend[63:0], divisor[31:0]                   valid / ready
// rsp      source quotient[63:0], remainder[31:0], divide_by_zero valid / ready
//
// The divider array has one register stage per quotient bit, each doing one 33-bit
// trial subtraction, and a result word is presented on rsp from the last of these
// stages. A new word may enter in every cycle in which the array is not held.
// Reset clears only the stage valid bits; no clearing pass is needed.
// The whole array advances together and holds, bubbles included, whenever the output
// register has a word that rsp does not take; nothing is lost or repeated.
module udiv64_by32_rem (
	input  wire logic  clk,
	input  wire logic  arst_n,
	udr_req_if.sink    req,
	udr_rsp_if.source  rsp
);

	localparam int unsigned Stages = udr_pkg::NumStages;

	// valid[k] and data[k] are the inputs to stage k; index Stages is the output register.
	logic               valid [Stages+1];
	udr_pkg::udr_data_t data  [Stages+1];
	logic               en;

	// The array moves whenever the output register is empty or being emptied.
	assign en        = !valid[Stages] || rsp.ready;
	assign req.ready = en;

	// The first step starts from a zero partial remainder with the full dividend
	// waiting to be shifted in.
	assign valid[0]        = req.valid;
	assign data[0].acc     = req.dividend;
	assign data[0].rem     = '0;
	assign data[0].divisor = req.divisor;

	for (genvar k = 0; k < Stages; k++) begin : g_stage
		udr_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (valid[k]),
			.data_in  (data[k]),
			.valid_s1 (valid[k+1]),
			.data_s1  (data[k+1])
		);
	end

	// After the last step the accumulator is the quotient. A zero divisor already
	// leaves an all-ones quotient and the low dividend word as remainder, so only
	// the flag needs deriving here.
	assign rsp.valid          = valid[Stages];
	assign rsp.quotient       = data[Stages].acc;
	assign rsp.remainder      = data[Stages].rem;
	assign rsp.divide_by_zero = (data[Stages].divisor == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/udr_checker.sv
`default_nettype none

module udr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [63:0] rsp_quotient,
	input wire logic [31:0] rsp_remainder,
	input wire logic        rsp_divide_by_zero
);

	// A result that is not taken stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient)
			&& $stable(rsp_remainder) && $stable(rsp_divide_by_zero))
		else $error("response word changed while stalled");

	// With the output register empty the array must keep taking words.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused while output register empty");

	// A zero divisor gives an all-ones quotient.
	a_dbz_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_divide_by_zero |-> rsp_quotient == '1)
		else $error("zero divisor without all-ones quotient");

	// Nothing leaves the array straight out of reset.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !rsp_valid)
		else $error("response word present just after reset");

endmodule

bind udiv64_by32_rem udr_checker u_udr_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_quotient       (rsp.quotient),
	.rsp_remainder      (rsp.remainder),
	.rsp_divide_by_zero (rsp.divide_by_zero)
);

`default_nettype wire

FILE: tb/udr_div_checker.sv
`default_nettype none

// Watches both channels of the divider, works out the quotient and remainder of
// every accepted request word and compares each response word against the oldest
// one still awaited.
module udr_div_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	udr_req_if        req,
	udr_rsp_if        rsp,
	output int        fail_count,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import udr_pkg::*;

	localparam int MaxReports = 10;

	typedef struct packed {
		logic [DividendWidth-1:0] quotient;
		logic [DivisorWidth-1:0]  remainder;
		logic                     divide_by_zero;
	} div_result_t;

	div_result_t pending_divisions[$];

	// A zero divisor gives an all-ones quotient and hands back the low dividend word.
	function automatic div_result_t divide_words(input logic [DividendWidth-1:0] dividend,
		input logic [DivisorWidth-1:0] divisor);
		div_result_t                res;
		logic [DividendWidth-1:0]   wide_divisor;
		wide_divisor = {{(DividendWidth-DivisorWidth){1'b0}}, divisor};
		if (divisor == '0) begin
			res.quotient       = '1;
			res.remainder      = dividend[DivisorWidth-1:0];
			res.divide_by_zero = 1'b1;
		end else begin
			res.quotient       = dividend / wide_divisor;
			res.remainder      = DivisorWidth'(dividend % wide_divisor);
			res.divide_by_zero = 1'b0;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : compare
		div_result_t want;
		int          errs;
		if (!arst_n) begin
			pending_divisions.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			errs = fail_count;
			// The response is taken first so that a word accepted on the same edge
			// is never mistaken for the one leaving.
			if (rsp.valid && rsp.ready) begin
				if (pending_divisions.size() == 0) begin
					if (errs < MaxReports)
						$display("%0t: result word with none awaited: q=%h r=%h dbz=%b",
							$realtime, rsp.quotient, rsp.remainder, rsp.divide_by_zero);
					errs++;
				end else begin
					want = pending_divisions.pop_front();
					if (rsp.quotient !== want.quotient || rsp.remainder !== want.remainder ||
						rsp.divide_by_zero !== want.divide_by_zero) begin
						if (errs < MaxReports)
							$display("%0t: mismatch q=%h/%h r=%h/%h dbz=%b/%b (expected/actual)",
								$realtime, want.quotient, rsp.quotient, want.remainder,
								rsp.remainder, want.divide_by_zero, rsp.divide_by_zero);
						errs++;
					end
				end
			end
			if (req.valid && req.ready)
				pending_divisions.push_back(divide_words(req.dividend, req.divisor));
			fail_count  <= errs;
			outstanding <= pending_divisions.size();
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

// Top of the divider bench. It drives request words, shapes the back-pressure on
// the response side, keeps a watchdog and gives the verdict; the checking is done
// in the checker modules, one beside the block and one bound into it.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import udr_pkg::*;

	localparam int unsigned RandWords     = 1200;
	localparam int unsigned HoldOffCycles = 400;
	// The array is one stage per quotient bit, so a little over that covers any
	// word that might still be on its way after the last expected one.
	localparam int unsigned SettleCycles  = NumStages + 8;
	localparam int unsigned IdleLimit     = 4000;

	typedef struct packed {
		logic [DividendWidth-1:0] dividend;
		logic [DivisorWidth-1:0]  divisor;
	} operand_pair_t;

	// Hand-picked corners: zero operands, division by zero with various low words,
	// the largest values, a dividend below or equal to the divisor, dividends whose
	// upper word is zero, and a remainder of one less than the divisor.
	localparam operand_pair_t Directed [20] = '{
		'{64'h0000_0000_0000_0000, 32'h0000_0001},
		'{64'h0000_0000_0000_0000, 32'h0000_0000},
		'{64'h0000_0000_0000_0001, 32'h0000_0000},
		'{64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000},
		'{64'h1234_5678_9ABC_DEF0, 32'h0000_0000},
		'{64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0001},
		'{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF},
		'{64'h0000_0000_0000_0001, 32'hFFFF_FFFF},
		'{64'h0000_0000_FFFF_FFFF, 32'h0000_0007},
		'{64'h0000_0000_0000_0005, 32'h0000_0009},
		'{64'h0000_0000_0000_3039, 32'h0000_3039},
		'{64'h8000_0000_0000_0000, 32'h0000_0003},
		'{64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF},
		'{64'h0000_0002_FFFF_FFFC, 32'hFFFF_FFFF},
		'{64'hDEAD_BEEF_CAFE_F00D, 32'h8000_0000},
		'{64'h0000_0001_0000_0000, 32'h0000_0002},
		'{64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_FFFE},
		'{64'h0000_0000_8000_0000, 32'h8000_0001},
		'{64'hAAAA_AAAA_5555_5555, 32'h5555_5555},
		'{64'h5555_5555_AAAA_AAAA, 32'hAAAA_AAAA}
	};

	logic clk;
	logic arst_n;

	udr_req_if req_ch();
	udr_rsp_if rsp_ch();

	int fail_count;
	int outstanding;
	int idle_cycles;
	int burst_left;
	bit random_phase;

	udiv64_by32_rem dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	udr_div_checker quotient_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #2ns clk = ~clk;

	// Offers one request word and returns on the edge at which it is taken. Words
	// go out in bursts; between most bursts valid drops for a random gap, and the payload
	// carries junk meanwhile so that nothing relies on it being held.
	task automatic push_word(input logic [DividendWidth-1:0] dividend,
		input logic [DivisorWidth-1:0] divisor);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_ch.valid    <= 1'b0;
				req_ch.dividend <= {$urandom, $urandom};
				req_ch.divisor  <= $urandom;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid    <= 1'b1;
		req_ch.dividend <= dividend;
		req_ch.divisor  <= divisor;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Waits until every awaited result word has been taken. The checker updates its
	// count on the edge itself, so the task waits for the clock before it first reads that count.
	task automatic drain_results();
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin : stimulus
		logic [DividendWidth-1:0] dividend;
		logic [DivisorWidth-1:0]  divisor;
		req_ch.valid    <= 1'b0;
		req_ch.dividend <= '0;
		req_ch.divisor  <= '0;
		arst_n          <= 1'b0;
		random_phase = 1'b0;
		burst_left   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (Directed[i])
			push_word(Directed[i].dividend, Directed[i].divisor);

		// From here on the receiver takes its one long hold-off while words keep
		// coming, so the array fills and the request side must stall.
		random_phase = 1'b1;
		for (int i = 0; i < RandWords; i++) begin
			// Halfway through, the sender stops until the block has emptied out.
			if (i == RandWords / 2) begin
				req_ch.valid <= 1'b0;
				drain_results();
			end
			case ($urandom_range(0, 9))
				0:       divisor = '0;
				1, 2:    divisor = $urandom_range(1, 16);
				3:       divisor = 32'd1 << $urandom_range(0, 31);
				4:       divisor = ~32'($urandom_range(0, 15));
				default: divisor = $urandom;
			endcase
			case ($urandom_range(0, 7))
				0:       dividend = {32'd0, 32'($urandom)};
				1:       dividend = {32'($urandom_range(0, 15)), 32'($urandom)};
				2:       dividend = ~64'($urandom_range(0, 3));
				3: begin
					// Land on an exact multiple, or just below the next one so the
					// remainder is as large as it can be.
					dividend = {$urandom, $urandom};
					if (divisor != '0) begin
						dividend = dividend - (dividend % {32'd0, divisor});
						if ($urandom_range(0, 1) == 1)
							dividend = dividend + {32'd0, divisor} - 64'd1;
					end
				end
				default: dividend = {$urandom, $urandom};
			endcase
			push_word(dividend, divisor);
		end

		req_ch.valid <= 1'b0;
		drain_results();
		repeat (SettleCycles) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Back-pressure on the response side: stretches of steady readiness, stretches
	// of random readiness at two densities and short full stops, plus one long
	// hold-off once the random words start.
	initial begin : rsp_stall
		int unsigned mode;
		int unsigned span;
		bit          held_off;
		held_off = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (random_phase && !held_off) begin
				held_off = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(5, 60);
				repeat (span) begin
					case (mode)
						0:       rsp_ch.ready <= 1'b1;
						1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
						2:       rsp_ch.ready <= ($urandom_range(0, 4) != 0);
						default: rsp_ch.ready <= 1'b0;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Ends the run if neither channel moves a word for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/udr_pkg.sv
hw/rtl/udr_if.sv
hw/rtl/udr_stage.sv
hw/rtl/udiv64_by32_rem.sv
hw/rtl/udr_checker.sv
tb/udr_div_checker.sv
tb/tb_top.sv
